/* sv/wlf_pkg.sv */
// Shared types and constants of the weighted line fit accumulator.
package wlf_pkg;

    localparam int MAX_HITS = 255;

    // running sum widths
    localparam int SW_W   = 24;
    localparam int SWR_W  = 40;
    localparam int SWZ_W  = 41;
    localparam int SWRZ_W = 57;
    localparam int SWZZ_W = 57;

    // solver datapath
    localparam int ACC_W   = 112;  // holds den << 31 and numerators after shift
    localparam int MB_W    = 42;   // multiplier operand, two's complement
    localparam int Q_W     = 32;   // quotient bits
    localparam int CNT_W   = 6;
    localparam int NS_SH   = 10;
    localparam int NI_SH   = 6;
    localparam int ERR_SH  = 32;

    localparam logic [31:0] SENT_NEG = 32'hFC19_0000;  // -999.0
    localparam logic [31:0] SENT_POS = 32'h03E7_0000;  //  999.0
    localparam logic [31:0] Q_MAX    = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN    = 32'h8000_0000;
    localparam logic [ACC_W-1:0] DEN_ONE = ACC_W'(1) << 24;  // 1.0 in Q.24
    localparam logic [6:0] LOW_SENSOR_RESET = 7'd100;

    typedef struct packed {
        logic [SW_W-1:0]   w;
        logic [SWR_W-1:0]  wr;
        logic [SWZ_W-1:0]  wz;    // signed
        logic [SWRZ_W-1:0] wrz;   // signed
        logic [SWZZ_W-1:0] wzz;
    } sums_t;

    typedef struct packed {
        logic [31:0] slope;
        logic [31:0] intercept;
        logic [31:0] err;
    } fit_t;

    typedef enum logic [2:0] {
        T_IDLE, T_M0, T_M1, T_M2, T_M3, T_M4, T_SOLVE, T_FIN
    } top_state_t;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_DEN, S_LOAD, S_CHK, S_DIV, S_STORE, S_DONE
    } fit_state_t;

    typedef enum logic [1:0] {
        DV_SLOPE, DV_INTERCEPT, DV_ERROR
    } div_sel_t;

endpackage

/* sv/wlf_fit_solver.sv */
// Line fit solver: shift-add products and restoring division on one shared adder.
module wlf_fit_solver import wlf_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  start,
    input  sums_t sums,
    output logic  done,
    output fit_t  fit
);

    fit_state_t state_reg, state_next;
    logic [2:0]       pidx_reg, pidx_next;
    logic [CNT_W-1:0] step_reg, step_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [ACC_W-1:0] mcand_reg, mcand_next;
    logic [MB_W-1:0]  mplier_reg, mplier_next;
    logic [ACC_W-1:0] den_reg, den_next;
    logic [ACC_W-1:0] ns_reg, ns_next;
    logic [ACC_W-1:0] ni_reg, ni_next;
    logic [ACC_W-1:0] rem_reg, rem_next;
    logic [ACC_W-1:0] dsh_reg, dsh_next;
    logic [Q_W-1:0]   q_reg, q_next;
    logic             den_neg_reg, den_neg_next;
    logic             qneg_reg, qneg_next;
    logic             sat_reg, sat_next;
    div_sel_t         didx_reg, didx_next;
    fit_t             fit_reg, fit_next;

    // shared adder / subtractor / comparator
    logic [ACC_W-1:0] add_x, add_y, add_sum;
    logic             add_sub, add_ge;
    logic [ACC_W:0]   add_full;

    assign add_full = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
                    + {{ACC_W{1'b0}}, add_sub};
    assign add_sum  = add_full[ACC_W-1:0];
    assign add_ge   = add_full[ACC_W];

    // product table: den = Szz*S0 - Sz*Sz, ns = Srz*S0 - Sr*Sz, ni = Sr*Szz - Srz*Sz
    function automatic logic [ACC_W-1:0] sel_a(input logic [2:0] idx, input sums_t s);
        logic [ACC_W-1:0] v;
        case (idx)
            3'd0, 3'd4: v = ACC_W'(s.wzz);
            3'd1, 3'd3: v = ACC_W'($signed(s.wz));
            default:    v = ACC_W'($signed(s.wrz));
        endcase
        return v;
    endfunction

    function automatic logic [MB_W-1:0] sel_b(input logic [2:0] idx, input sums_t s);
        logic [MB_W-1:0] v;
        case (idx)
            3'd0, 3'd2: v = MB_W'(s.w);
            3'd3, 3'd4: v = MB_W'(s.wr);
            default:    v = MB_W'($signed(s.wz));
        endcase
        return v;
    endfunction

    logic [ACC_W-1:0] acc_step, num, mag;
    logic [Q_W-1:0]   qres;
    logic             qover;

    always_comb begin
        state_next   = state_reg;
        pidx_next    = pidx_reg;
        step_next    = step_reg;
        acc_next     = acc_reg;
        mcand_next   = mcand_reg;
        mplier_next  = mplier_reg;
        den_next     = den_reg;
        ns_next      = ns_reg;
        ni_next      = ni_reg;
        rem_next     = rem_reg;
        dsh_next     = dsh_reg;
        q_next       = q_reg;
        den_neg_next = den_neg_reg;
        qneg_next    = qneg_reg;
        sat_next     = sat_reg;
        didx_next    = didx_reg;
        fit_next     = fit_reg;
        add_x        = '0;
        add_y        = '0;
        add_sub      = 1'b0;
        done         = 1'b0;
        acc_step     = acc_reg;
        num          = '0;
        mag          = '0;
        qover        = 1'b0;
        qres         = '0;
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    pidx_next   = 3'd0;
                    mcand_next  = sel_a(3'd0, sums);
                    mplier_next = sel_b(3'd0, sums);
                    step_next   = '0;
                    acc_next    = '0;
                    state_next  = S_MUL;
                end
            end
            S_MUL: begin
                // top multiplier bit carries negative weight
                add_x       = acc_reg;
                add_y       = mcand_reg;
                add_sub     = pidx_reg[0] ^ (step_reg == CNT_W'(MB_W - 1));
                acc_step    = mplier_reg[0] ? add_sum : acc_reg;
                acc_next    = acc_step;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                step_next   = step_reg + 1'b1;
                if (step_reg == CNT_W'(MB_W - 1)) begin
                    if (pidx_reg[0]) begin
                        case (pidx_reg[2:1])
                            2'd0:    den_next = acc_step;
                            2'd1:    ns_next  = acc_step;
                            default: ni_next  = acc_step;
                        endcase
                    end
                    if (pidx_reg == 3'd5) begin
                        state_next = S_DEN;
                    end else begin
                        pidx_next   = pidx_reg + 1'b1;
                        mcand_next  = sel_a(pidx_reg + 1'b1, sums);
                        mplier_next = sel_b(pidx_reg + 1'b1, sums);
                        step_next   = '0;
                        if (pidx_reg[0]) begin
                            acc_next = '0;
                        end
                    end
                end
            end
            S_DEN: begin
                if (den_reg == '0) begin
                    den_next     = DEN_ONE;
                    den_neg_next = 1'b0;
                end else begin
                    add_y        = den_reg;
                    add_sub      = 1'b1;
                    den_neg_next = den_reg[ACC_W-1];
                    if (den_reg[ACC_W-1]) begin
                        den_next = add_sum;
                    end
                end
                didx_next  = DV_SLOPE;
                state_next = S_LOAD;
            end
            S_LOAD: begin
                case (didx_reg)
                    DV_SLOPE:     num = ns_reg;
                    DV_INTERCEPT: num = ni_reg;
                    default:      num = ACC_W'(sums.w);
                endcase
                add_y   = num;
                add_sub = 1'b1;
                mag     = num[ACC_W-1] ? add_sum : num;
                case (didx_reg)
                    DV_SLOPE:     rem_next = mag << NS_SH;
                    DV_INTERCEPT: rem_next = mag << NI_SH;
                    default:      rem_next = mag << ERR_SH;
                endcase
                qneg_next  = num[ACC_W-1] ^ den_neg_reg;
                state_next = S_CHK;
            end
            S_CHK: begin
                // quotient needs more than 32 bits: saturate
                add_x   = rem_reg >> Q_W;
                add_y   = den_reg;
                add_sub = 1'b1;
                if (add_ge) begin
                    sat_next   = 1'b1;
                    state_next = S_STORE;
                end else begin
                    sat_next   = 1'b0;
                    dsh_next   = den_reg << (Q_W - 1);
                    step_next  = '0;
                    q_next     = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                add_x   = rem_reg;
                add_y   = dsh_reg;
                add_sub = 1'b1;
                if (add_ge) begin
                    rem_next = add_sum;
                end
                q_next    = {q_reg[Q_W-2:0], add_ge};
                dsh_next  = dsh_reg >> 1;
                step_next = step_reg + 1'b1;
                if (step_reg == CNT_W'(Q_W - 1)) begin
                    state_next = S_STORE;
                end
            end
            S_STORE: begin
                qover = sat_reg || (qneg_reg ? (q_reg > Q_MIN) : q_reg[Q_W-1]);
                if (qover) begin
                    qres = qneg_reg ? Q_MIN : Q_MAX;
                end else begin
                    qres = qneg_reg ? (Q_W'(0) - q_reg) : q_reg;
                end
                case (didx_reg)
                    DV_SLOPE: begin
                        fit_next.slope = qres;
                        didx_next      = DV_INTERCEPT;
                        state_next     = S_LOAD;
                    end
                    DV_INTERCEPT: begin
                        fit_next.intercept = qres;
                        didx_next          = DV_ERROR;
                        state_next         = S_LOAD;
                    end
                    default: begin
                        fit_next.err = qres;
                        state_next   = S_DONE;
                    end
                endcase
            end
            S_DONE: begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        pidx_reg    <= pidx_next;
        step_reg    <= step_next;
        acc_reg     <= acc_next;
        mcand_reg   <= mcand_next;
        mplier_reg  <= mplier_next;
        den_reg     <= den_next;
        ns_reg      <= ns_next;
        ni_reg      <= ni_next;
        rem_reg     <= rem_next;
        dsh_reg     <= dsh_next;
        q_reg       <= q_next;
        den_neg_reg <= den_neg_next;
        qneg_reg    <= qneg_next;
        sat_reg     <= sat_next;
        didx_reg    <= didx_next;
        fit_reg     <= fit_next;
    end

    assign fit = fit_reg;

`ifndef SYNTHESIS
    a_start_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && start) |=> (state_reg == S_MUL))
        else $error("solver did not start product phase");
    a_den_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (den_reg != '0 && !den_reg[ACC_W-1]))
        else $error("divisor not a positive magnitude");
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> ((rem_reg >> 1) < dsh_reg))
        else $error("division remainder out of range");
`endif

endmodule

/* sv/weighted_line_fit_accumulator_unit.sv */
// Top level of the weighted line fit accumulator: hit sums, sequencing, result register.
//
// Each transfer on the s_ channel is one detector hit; each hit yields exactly one
// transfer on the m_ channel. A hit with s_first_hit set starts a new track: sums,
// hit count, sensor extremes and the held fit return to their reset values first.
// The hit is folded into weighted sums of w, w*r, w*z, w*r*z and w*z*z using one
// 33x17 signed multiplier, a product at a time. From the third hit of a track on, the
// fit (slope, intercept, slope error, Q16.16, truncated toward zero, saturated) is
// solved exactly by a sequencer around a single 112-bit adder: six 42-step
// shift-add products build the determinant and both numerators, then three
// restoring divisions of 32 steps each (with an up-front overflow compare) give
// the quotients. A zero determinant is taken as 1.0. Before three hits the fit
// fields read -999, -999 and 999. Once a track holds 255 hits further hits are
// ignored and the result repeats the track state. An ignored hit skips the products,
// the first two hits of a track skip the solve, and a solved hit takes longest, set
// by the bit-serial products and divisions on the shared adder; each also waits
// while the output register is full. s_ready is high only while no hit is in work;
// a finished result waits in the output register, so the next hit can be taken
// before m_ready arrives.
module weighted_line_fit_accumulator_unit import wlf_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_first_hit,
    input  logic [6:0]         s_sensor,
    input  logic signed [15:0] s_hit_z,
    input  logic [15:0]        s_hit_r,
    input  logic [15:0]        s_hit_weight,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_fit_valid,
    output logic signed [31:0] m_slope,
    output logic signed [31:0] m_intercept,
    output logic signed [31:0] m_slope_error,
    output logic [7:0]         m_hit_count,
    output logic [6:0]         m_min_sensor,
    output logic [6:0]         m_max_sensor
);

    top_state_t state_reg, state_next;

    // track state
    sums_t      sums_reg, sums_next;
    logic [7:0] count_reg, count_next;
    logic [6:0] low_reg, low_next;
    logic [6:0] high_reg, high_next;
    fit_t       held_reg, held_next;

    // captured hit and partial products
    logic [6:0]         sensor_reg, sensor_next;
    logic signed [15:0] z_reg, z_next;
    logic [15:0]        r_reg, r_next;
    logic [15:0]        w_reg, w_next;
    logic [31:0]        wr_reg, wr_next;
    logic signed [32:0] wz_reg, wz_next;

    // hit multiplier, registered output
    logic signed [32:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [49:0] prod_next, prod_reg;

    assign prod_next = mul_a * mul_b;

    // result register
    logic        m_valid_reg, m_valid_next;
    logic        o_fit_valid_reg, o_fit_valid_next;
    fit_t        o_fit_reg, o_fit_next;
    logic [7:0]  o_count_reg, o_count_next;
    logic [6:0]  o_low_reg, o_low_next;
    logic [6:0]  o_high_reg, o_high_next;

    logic fit_start, fit_done;
    fit_t fit_res;

    // solver sees the sums including the hit folded in on its start cycle
    wlf_fit_solver u_solver (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (fit_start),
        .sums    (sums_next),
        .done    (fit_done),
        .fit     (fit_res)
    );

    always_comb begin
        state_next       = state_reg;
        sums_next        = sums_reg;
        count_next       = count_reg;
        low_next         = low_reg;
        high_next        = high_reg;
        held_next        = held_reg;
        sensor_next      = sensor_reg;
        z_next           = z_reg;
        r_next           = r_reg;
        w_next           = w_reg;
        wr_next          = wr_reg;
        wz_next          = wz_reg;
        m_valid_next     = m_valid_reg;
        o_fit_valid_next = o_fit_valid_reg;
        o_fit_next       = o_fit_reg;
        o_count_next     = o_count_reg;
        o_low_next       = o_low_reg;
        o_high_next      = o_high_reg;
        mul_a            = '0;
        mul_b            = '0;
        fit_start        = 1'b0;
        s_ready          = (state_reg == T_IDLE);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            T_IDLE: begin
                if (s_valid) begin
                    sensor_next = s_sensor;
                    z_next      = s_hit_z;
                    r_next      = s_hit_r;
                    w_next      = s_hit_weight;
                    if (s_first_hit) begin
                        sums_next  = '0;
                        count_next = '0;
                        low_next   = LOW_SENSOR_RESET;
                        high_next  = '0;
                        held_next  = '{slope: SENT_NEG, intercept: SENT_NEG, err: SENT_POS};
                    end
                    // a full track ignores the hit
                    if (!s_first_hit && count_reg == 8'(MAX_HITS)) begin
                        state_next = T_FIN;
                    end else begin
                        state_next = T_M0;
                    end
                end
            end
            T_M0: begin
                mul_a      = $signed(33'(w_reg));
                mul_b      = $signed(17'(r_reg));
                state_next = T_M1;
            end
            T_M1: begin
                sums_next.wr = sums_reg.wr + SWR_W'(prod_reg[31:0]);
                wr_next      = prod_reg[31:0];
                mul_a        = $signed(33'(w_reg));
                mul_b        = 17'(z_reg);
                state_next   = T_M2;
            end
            T_M2: begin
                sums_next.wz = sums_reg.wz + SWZ_W'(prod_reg);
                wz_next      = prod_reg[32:0];
                mul_a        = $signed({1'b0, wr_reg});
                mul_b        = 17'(z_reg);
                state_next   = T_M3;
            end
            T_M3: begin
                sums_next.wrz = sums_reg.wrz + SWRZ_W'(prod_reg);
                mul_a         = wz_reg;
                mul_b         = 17'(z_reg);
                state_next    = T_M4;
            end
            T_M4: begin
                sums_next.wzz = sums_reg.wzz + SWZZ_W'(prod_reg);
                sums_next.w   = sums_reg.w + SW_W'(w_reg);
                count_next    = count_reg + 1'b1;
                if (sensor_reg > high_reg) begin
                    high_next = sensor_reg;
                end
                if (sensor_reg < low_reg) begin
                    low_next = sensor_reg;
                end
                // third hit on: solve with the updated sums
                if (count_reg >= 8'd2) begin
                    fit_start  = 1'b1;
                    state_next = T_SOLVE;
                end else begin
                    state_next = T_FIN;
                end
            end
            T_SOLVE: begin
                if (fit_done) begin
                    held_next  = fit_res;
                    state_next = T_FIN;
                end
            end
            T_FIN: begin
                // output register free or being emptied this cycle
                if (!m_valid_reg || m_ready) begin
                    m_valid_next     = 1'b1;
                    o_fit_valid_next = (count_reg > 8'd2);
                    o_fit_next       = held_reg;
                    o_count_next     = count_reg;
                    o_low_next       = low_reg;
                    o_high_next      = high_reg;
                    state_next       = T_IDLE;
                end
            end
            default: state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            m_valid_reg <= 1'b0;
            sums_reg    <= '0;
            count_reg   <= '0;
            low_reg     <= LOW_SENSOR_RESET;
            high_reg    <= '0;
            held_reg    <= '{slope: SENT_NEG, intercept: SENT_NEG, err: SENT_POS};
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            sums_reg    <= sums_next;
            count_reg   <= count_next;
            low_reg     <= low_next;
            high_reg    <= high_next;
            held_reg    <= held_next;
        end
    end

    always_ff @(posedge aclk) begin
        sensor_reg      <= sensor_next;
        z_reg           <= z_next;
        r_reg           <= r_next;
        w_reg           <= w_next;
        wr_reg          <= wr_next;
        wz_reg          <= wz_next;
        prod_reg        <= prod_next;
        o_fit_valid_reg <= o_fit_valid_next;
        o_fit_reg       <= o_fit_next;
        o_count_reg     <= o_count_next;
        o_low_reg       <= o_low_next;
        o_high_reg      <= o_high_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_fit_valid   = o_fit_valid_reg;
    assign m_slope       = $signed(o_fit_reg.slope);
    assign m_intercept   = $signed(o_fit_reg.intercept);
    assign m_slope_error = $signed(o_fit_reg.err);
    assign m_hit_count   = o_count_reg;
    assign m_min_sensor  = o_low_reg;
    assign m_max_sensor  = o_high_reg;

`ifndef SYNTHESIS
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("hit taken while previous hit in work");
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 8'(MAX_HITS))
        else $error("hit count beyond track capacity");
    a_fit_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_fit_valid == (m_hit_count > 8'd2)))
        else $error("fit flag disagrees with hit count");
    a_sensor_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_hit_count != 8'd0) |-> (m_min_sensor <= m_max_sensor))
        else $error("sensor extremes out of order");
`endif

endmodule

/* tb/weighted_line_fit_accumulator_unit_tb.sv */
// Self-checking testbench for the weighted line fit accumulator top level.
module weighted_line_fit_accumulator_unit_tb import wlf_pkg::*; ();

    localparam int  LIMIT_CYCLES = 4_000_000;
    localparam int  DRAIN_CYCLES = 800;
    localparam int  REPORT_MAX   = 10;

    typedef struct packed {
        logic        fit_valid;
        logic [31:0] slope;
        logic [31:0] intercept;
        logic [31:0] slope_error;
        logic [7:0]  hit_count;
        logic [6:0]  min_sensor;
        logic [6:0]  max_sensor;
    } fit_result_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_first_hit;
    logic [6:0]         s_sensor;
    logic signed [15:0] s_hit_z;
    logic [15:0]        s_hit_r;
    logic [15:0]        s_hit_weight;
    logic               m_valid;
    logic               m_ready;
    logic               m_fit_valid;
    logic signed [31:0] m_slope;
    logic signed [31:0] m_intercept;
    logic signed [31:0] m_slope_error;
    logic [7:0]         m_hit_count;
    logic [6:0]         m_min_sensor;
    logic [6:0]         m_max_sensor;

    weighted_line_fit_accumulator_unit u_top (.*);

    // track state mirrored by the predictor
    logic signed [63:0] acc_w, acc_wr, acc_wz, acc_wrz, acc_wzz;
    int unsigned        hits;
    logic [6:0]         sensor_lo, sensor_hi;
    logic [31:0]        fit_slope, fit_icpt, fit_err;

    fit_result_t        pending_fits[$];
    int unsigned        mismatches = 0;
    int unsigned        cycles = 0;
    bit                 steady_mode;   // no idling on either side while set

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("weighted_line_fit_accumulator_unit_tb: done, errors");
            $finish;
        end
    end

    function automatic int unsigned idle_draw();
        if (steady_mode || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 18);
    endfunction

    function automatic void clear_track();
        acc_w = 0; acc_wr = 0; acc_wz = 0; acc_wrz = 0; acc_wzz = 0;
        hits = 0;
        sensor_lo = LOW_SENSOR_RESET;
        sensor_hi = '0;
        fit_slope = SENT_NEG;
        fit_icpt  = SENT_NEG;
        fit_err   = SENT_POS;
    endfunction

    // n * 2^sh / d, truncated toward zero, saturated to signed 32 bits
    function automatic logic [31:0] quot_sat(logic signed [127:0] n, int sh,
                                             logic signed [127:0] d);
        logic        neg;
        logic [127:0] an, ad, q, lim;
        neg = n[127] ^ d[127];
        an  = n[127] ? -n : n;
        ad  = d[127] ? -d : d;
        q   = (an << sh) / ad;
        lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
        if (q > lim)
            return neg ? Q_MIN : Q_MAX;
        return neg ? 32'(-q) : q[31:0];
    endfunction

    // fold one accepted hit into the track and return the result it should produce
    function automatic fit_result_t fold_hit(logic first, logic [6:0] sen,
                                             logic signed [15:0] z, logic [15:0] r,
                                             logic [15:0] w);
        logic signed [63:0]  wz, wr;
        logic signed [127:0] den, nsl, nic;
        fit_result_t         res;
        if (first)
            clear_track();
        if (hits < MAX_HITS) begin
            if (sen > sensor_hi) sensor_hi = sen;
            if (sen < sensor_lo) sensor_lo = sen;
            hits++;
            wz = $signed({48'd0, w}) * 64'(z);
            wr = $signed({48'd0, w}) * $signed({48'd0, r});
            acc_w   += $signed({48'd0, w});
            acc_wr  += wr;
            acc_wz  += wz;
            acc_wrz += wr * 64'(z);
            acc_wzz += wz * 64'(z);
            if (hits > 2) begin
                den = 128'(acc_wzz) * 128'(acc_w) - 128'(acc_wz) * 128'(acc_wz);
                nsl = 128'(acc_wrz) * 128'(acc_w) - 128'(acc_wr) * 128'(acc_wz);
                nic = 128'(acc_wr) * 128'(acc_wzz) - 128'(acc_wrz) * 128'(acc_wz);
                if (den == 0)
                    den = 128'(1) << 24;   // degenerate geometry: unit determinant
                fit_slope = quot_sat(nsl, NS_SH, den);
                fit_icpt  = quot_sat(nic, NI_SH, den);
                fit_err   = quot_sat(128'(acc_w), ERR_SH, den);
            end
        end
        res.fit_valid   = hits > 2;
        res.slope       = fit_slope;
        res.intercept   = fit_icpt;
        res.slope_error = fit_err;
        res.hit_count   = 8'(hits);
        res.min_sensor  = sensor_lo;
        res.max_sensor  = sensor_hi;
        return res;
    endfunction

    // drive one hit and hold it until the transfer; called at a rising edge
    task automatic send_hit(logic first, logic [6:0] sen, logic signed [15:0] z,
                            logic [15:0] r, logic [15:0] w);
        int unsigned gap;
        fit_result_t pred_res;
        s_valid      <= 1'b1;
        s_first_hit  <= first;
        s_sensor     <= sen;
        s_hit_z      <= z;
        s_hit_r      <= r;
        s_hit_weight <= w;
        do @(posedge aclk); while (!s_ready);
        pred_res     = fold_hit(first, sen, z, r, w);
        pending_fits = {pending_fits, pred_res};
        gap = idle_draw();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_random_hit(logic first);
        send_hit(first, 7'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // result side: random stalls, each transfer checked against the oldest prediction
    initial begin : result_check
        fit_result_t got, want;
        int unsigned stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            stall = idle_draw();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got = {m_fit_valid, m_slope, m_intercept, m_slope_error,
                   m_hit_count, m_min_sensor, m_max_sensor};
            if (pending_fits.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result transfer: %p", got);
            end else begin
                want = pending_fits.pop_front();
                if (got.fit_valid !== want.fit_valid || got.slope !== want.slope ||
                    got.intercept !== want.intercept ||
                    got.slope_error !== want.slope_error ||
                    got.hit_count !== want.hit_count ||
                    got.min_sensor !== want.min_sensor ||
                    got.max_sensor !== want.max_sensor) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("result mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    // field extremes, sensor extremes, sentinels before the third hit
    task automatic test_extremes();
        send_hit(1'b0, 7'd50, 16'sd0, 16'd0, 16'd0);        // no track start after reset
        send_hit(1'b1, 7'd127, -16'sd32768, 16'hFFFF, 16'hFFFF);
        send_hit(1'b0, 7'd0, 16'sd32767, 16'd0, 16'hFFFF);
        send_hit(1'b0, 7'd64, 16'sd0, 16'hFFFF, 16'd1);
        send_hit(1'b0, 7'd100, -16'sd1, 16'h8000, 16'h0100);
        send_hit(1'b1, 7'd101, 16'sd16, 16'd1024, 16'h0100);
        send_hit(1'b0, 7'd99, 16'sd32, 16'd2048, 16'h0100);
        send_hit(1'b0, 7'd5, 16'sd48, 16'd3072, 16'h0100);
        // steep line to push slope into saturation
        send_hit(1'b1, 7'd10, 16'sd0, 16'd0, 16'hFFFF);
        send_hit(1'b0, 7'd11, 16'sd1, 16'hFFFF, 16'hFFFF);
        send_hit(1'b0, 7'd12, 16'sd2, 16'd0, 16'hFFFF);
        send_hit(1'b0, 7'd13, -16'sd1, 16'hFFFF, 16'd1);
    endtask

    // zero determinant: all hits at one z, and all weights zero
    task automatic test_zero_determinant();
        send_hit(1'b1, 7'd20, 16'sd400, 16'd100, 16'd300);
        send_hit(1'b0, 7'd21, 16'sd400, 16'd900, 16'd7);
        send_hit(1'b0, 7'd22, 16'sd400, 16'd5, 16'hFFFF);
        send_hit(1'b1, 7'd30, 16'sd1, 16'd1, 16'd0);
        send_hit(1'b0, 7'd31, -16'sd5, 16'd2, 16'd0);
        send_hit(1'b0, 7'd32, 16'sd9, 16'd3, 16'd0);
    endtask

    // track full: hits beyond the limit repeat the held state
    task automatic test_full_track();
        steady_mode = 1'b1;
        send_random_hit(1'b1);
        repeat (MAX_HITS + 2) send_random_hit(1'b0);
        steady_mode = 1'b0;
    endtask

    // random tracks, mostly short; some hits outside any clean track start
    task automatic test_random_tracks();
        int unsigned sent, len;
        sent = 0;
        while (sent < 2000) begin
            steady_mode = ($urandom_range(0, 7) == 0);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                             : $urandom_range(1, 8);
            send_random_hit($urandom_range(0, 9) != 0);
            repeat (len - 1) send_random_hit($urandom_range(0, 29) == 0);
            sent += len;
        end
        steady_mode = 1'b0;
    endtask

    initial begin
        steady_mode  = 1'b0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_first_hit  = 1'b0;
        s_sensor     = '0;
        s_hit_z      = '0;
        s_hit_r      = '0;
        s_hit_weight = '0;
        clear_track();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_extremes();
        test_zero_determinant();
        test_full_track();
        test_random_tracks();

        s_valid <= 1'b0;
        while (pending_fits.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("weighted_line_fit_accumulator_unit_tb: done, clean");
        else
            $display("weighted_line_fit_accumulator_unit_tb: done, errors");
        $finish;
    end

endmodule
